// ===== rtl/core/awsp_pkg.sv =====
`default_nettype none
package awsp_pkg;

	// pipeline layout
	localparam int NSTG          = 44;
	localparam int STG_SC_FIRST  = 3;
	localparam int STG_SC_LAST   = 20;
	localparam int STG_DIV_FIRST = 26;
	localparam int STG_DIV_LAST  = 43;

	localparam int QBITS = 15;

	// pi/18000 in Q40, so that (a * K + 512) >> 10 gives radians in Q30
	localparam logic [27:0] HALF_TURN_Q30_K = 28'd191900981;
	localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

	localparam logic signed [15:0] SPEED_MAX = 16'sd32767;

	// configuration register indexes
	localparam int          CFG_IDX_W      = 2;
	localparam logic [1:0]  REG_WHEEL_BASE = 2'd0;
	localparam logic [1:0]  REG_BASE_SPEED = 2'd1;
	localparam logic [7:0]  WHEEL_BASE_RST = 8'd50;
	localparam logic [14:0] BASE_SPEED_RST = 15'd1500;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_AT_ROBOT = 2'd1,
		ST_PIVOT    = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	// octant fold of the heading
	typedef struct packed {
		logic [1:0] quad;
		logic       swap;
	} fold_t;

	// special cases carried alongside the divider
	typedef struct packed {
		logic at_robot;
		logic straight;
		logic dzero;
		logic neg;
	} case_t;

endpackage
`default_nettype wire

// ===== rtl/core/arc_wheel_speed_planner.sv =====
`default_nettype none
// Channel | dir | handshake        | content
// s_      | in  | tvalid / tready  | tdata: robot_x, robot_y, heading_centideg, target_x,
//         |     |                  |        target_y (low bits first), zero padded
// m_      | out | tvalid / tready  | tdata: left_speed, right_speed; tuser: status
// cfg_    | in  | valid / ready    | index 0 wheel_base_cm, 1 base_speed_mm_s; ready always high
//
// 44 register stages; one item per cycle with no back-pressure.
// Depth is set by the Horner sine/cosine chain (five steps of three stages) and the
// restoring divider (15 quotient-bit stages) for the right speed ratio.
// Reset clears all valid bits and loads the register defaults (50 cm, 1500 mm/s).
// A stage takes a new item when it is empty or the stage after it moves, so a
// stalled output only halts the stages that hold items; bubbles are squeezed out.
module arc_wheel_speed_planner #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// slave side
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// robot_x, robot_y, heading_centideg(17), target_x, target_y
	input  wire logic [((4*COORD_BITS+17+7)/8)*8-1:0] s_tdata,
	// master side
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// left_speed(16), right_speed(16)
	output logic [31:0]                            m_tdata,
	// status(2)
	output logic [1:0]                             m_tuser,
	// configuration
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [awsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [14:0]                       cfg_data
);
	localparam int C  = COORD_BITS;
	localparam int N  = awsp_pkg::NSTG;
	localparam int XW = C + 4;         // rounded rotated offset
	localparam int W  = 2 * C + 8;     // S and b*|yy| sums

	// ---------------- configuration ----------------
	logic [7:0]  wb_q;
	logic [14:0] bs_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= awsp_pkg::WHEEL_BASE_RST;
			bs_q <= awsp_pkg::BASE_SPEED_RST;
		end else if (cfg_valid) begin
			if (cfg_index == awsp_pkg::REG_WHEEL_BASE)
				wb_q <= cfg_data[7:0];
			else if (cfg_index == awsp_pkg::REG_BASE_SPEED)
				bs_q <= cfg_data;
		end
	end

	// ---------------- valid bits and stage enables ----------------
	logic [N:1] vld_s;
	logic [N:1] en;

	always_comb begin
		en[N] = !vld_s[N] || m_tready;
		for (int k = N - 1; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= s_tvalid;
			for (int k = 2; k <= N; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------- stage 1: offsets, heading mod 36000 ----------------
	logic signed [C-1:0]  rx, ry, tx, ty;
	logic signed [16:0]   hd;
	logic signed [18:0]   hw, hr;

	assign rx = s_tdata[C-1:0];
	assign ry = s_tdata[2*C-1:C];
	assign hd = s_tdata[2*C+16:2*C];
	assign tx = s_tdata[3*C+16:2*C+17];
	assign ty = s_tdata[4*C+16:3*C+17];
	assign hw = 19'(hd);

	always_comb begin
		if (hw < -19'sd36000)
			hr = hw + 19'sd72000;
		else if (hw < 19'sd0)
			hr = hw + 19'sd36000;
		else if (hw >= 19'sd36000)
			hr = hw - 19'sd36000;
		else
			hr = hw;
	end

	logic signed [C:0] dx_s [1:20];
	logic signed [C:0] dy_s [1:20];
	logic [15:0]       r_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dx_s[1] <= (C+1)'(tx) - (C+1)'(rx);
			dy_s[1] <= (C+1)'(ty) - (C+1)'(ry);
			r_s1    <= hr[15:0];
		end
		for (int k = 2; k <= 20; k++)
			if (en[k]) begin
				dx_s[k] <= dx_s[k-1];
				dy_s[k] <= dy_s[k-1];
			end
	end

	// ---------------- stage 2: quadrant and octant fold ----------------
	logic [1:0]      quad;
	logic [15:0]     a_in_q;
	logic [12:0]     af_s2;
	awsp_pkg::fold_t fold_s2;

	always_comb begin
		if (r_s1 < 16'd9000) begin
			quad = 2'd0; a_in_q = r_s1;
		end else if (r_s1 < 16'd18000) begin
			quad = 2'd1; a_in_q = r_s1 - 16'd9000;
		end else if (r_s1 < 16'd27000) begin
			quad = 2'd2; a_in_q = r_s1 - 16'd18000;
		end else begin
			quad = 2'd3; a_in_q = r_s1 - 16'd27000;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			fold_s2.quad <= quad;
			fold_s2.swap <= a_in_q > 16'd4500;
			af_s2        <= (a_in_q > 16'd4500) ? 13'(16'd9000 - a_in_q) : a_in_q[12:0];
		end
	end

	// ---------------- stages 3..20: sine and cosine ----------------
	logic signed [17:0] sin_s20, cos_s20;

	awsp_sincos u_sincos (
		.clk     (clk),
		.en      (en[awsp_pkg::STG_SC_LAST:awsp_pkg::STG_SC_FIRST]),
		.af_in   (af_s2),
		.fold_in (fold_s2),
		.sin_q16 (sin_s20),
		.cos_q16 (cos_s20)
	);

	// ---------------- stage 21: rotation products ----------------
	logic signed [C+18:0] pxc_s21, pys_s21, pyc_s21, pxs_s21;

	always_ff @(posedge clk) begin
		if (en[21]) begin
			pxc_s21 <= (C+19)'(dx_s[20]) * (C+19)'(cos_s20);
			pys_s21 <= (C+19)'(dy_s[20]) * (C+19)'(sin_s20);
			pyc_s21 <= (C+19)'(dy_s[20]) * (C+19)'(cos_s20);
			pxs_s21 <= (C+19)'(dx_s[20]) * (C+19)'(sin_s20);
		end
	end

	// ---------------- stage 22: sums, round to cm ----------------
	// add one half, then truncate toward zero
	logic signed [C+20:0] wx, wy, nwx, nwy;
	logic signed [XW-1:0] xx_c, yy_c;

	always_comb begin
		wx  = (C+21)'(pxc_s21) + (C+21)'(pys_s21) + (C+21)'(32768);
		wy  = (C+21)'(pyc_s21) - (C+21)'(pxs_s21) + (C+21)'(32768);
		nwx = -wx;
		nwy = -wy;
		if (wx >= 0) xx_c = XW'(wx >>> 16);
		else         xx_c = -XW'(nwx >>> 16);
		if (wy >= 0) yy_c = XW'(wy >>> 16);
		else         yy_c = -XW'(nwy >>> 16);
	end

	logic signed [XW-1:0] xx_s22, yy_s22;

	always_ff @(posedge clk) begin
		if (en[22]) begin
			xx_s22 <= xx_c;
			yy_s22 <= yy_c;
		end
	end

	// ---------------- stage 23: left speed, squares, b*|yy| ----------------
	logic signed [XW-1:0] axs, ays;
	logic [XW-2:0]        ax, ay;

	assign axs = xx_s22[XW-1] ? -xx_s22 : xx_s22;
	assign ays = yy_s22[XW-1] ? -yy_s22 : yy_s22;
	assign ax  = axs[XW-2:0];
	assign ay  = ays[XW-2:0];

	logic signed [15:0] left_s [23:43];
	logic [2*XW-3:0]    xsq_s23, ysq_s23;
	logic [XW+6:0]      p_s23, p_s24;
	logic               ar_s23, st_s23, yp_s23, ar_s24, st_s24, yp_s24;
	logic [W-2:0]       sq_s24;

	always_ff @(posedge clk) begin
		if (en[23]) begin
			left_s[23] <= xx_s22[XW-1] ? -16'(bs_q) : 16'(bs_q);
			xsq_s23    <= (2*XW-2)'(ax) * (2*XW-2)'(ax);
			ysq_s23    <= (2*XW-2)'(ay) * (2*XW-2)'(ay);
			p_s23      <= (XW+7)'(ay) * (XW+7)'(wb_q);
			ar_s23     <= (xx_s22 == '0) && (yy_s22 == '0);
			st_s23     <= yy_s22 == '0;
			yp_s23     <= !yy_s22[XW-1] && (yy_s22 != '0);
		end
		for (int k = 24; k <= 43; k++)
			if (en[k])
				left_s[k] <= left_s[k-1];
		// stage 24: S = xx^2 + yy^2
		if (en[24]) begin
			sq_s24 <= (W-1)'(xsq_s23) + (W-1)'(ysq_s23);
			p_s24  <= p_s23;
			ar_s24 <= ar_s23;
			st_s24 <= st_s23;
			yp_s24 <= yp_s23;
		end
	end

	// ---------------- stage 25: numerator, denominator, signs ----------------
	logic [W-1:0] sum_a, dif_b;
	logic         b_neg;
	logic [W-1:0] n_c, d_c;
	logic         n_neg, d_neg;

	always_comb begin
		sum_a = W'(sq_s24) + W'(p_s24);
		b_neg = W'(sq_s24) < W'(p_s24);
		dif_b = b_neg ? W'(p_s24) - W'(sq_s24) : W'(sq_s24) - W'(p_s24);
		if (yp_s24) begin
			n_c = sum_a; n_neg = 1'b0;
			d_c = dif_b; d_neg = b_neg;
		end else begin
			n_c = dif_b; n_neg = b_neg;
			d_c = sum_a; d_neg = 1'b0;
		end
	end

	logic [W-1:0]    n_s25, d_s25;
	awsp_pkg::case_t cs_s [25:43];

	always_ff @(posedge clk) begin
		if (en[25]) begin
			n_s25             <= n_c;
			d_s25             <= d_c;
			cs_s[25].at_robot <= ar_s24;
			cs_s[25].straight <= st_s24;
			cs_s[25].dzero    <= d_c == '0;
			cs_s[25].neg      <= left_s[24][15] != (n_neg != d_neg);
		end
		for (int k = 26; k <= 43; k++)
			if (en[k])
				cs_s[k] <= cs_s[k-1];
	end

	// ---------------- stages 26..43: rounded ratio ----------------
	logic [awsp_pkg::QBITS-1:0] q_s43;
	logic                       sat_s43;

	awsp_div #(.W(W)) u_div (
		.clk     (clk),
		.en      (en[awsp_pkg::STG_DIV_LAST:awsp_pkg::STG_DIV_FIRST]),
		.n_in    (n_s25),
		.d_in    (d_s25),
		.base    (bs_q),
		.q_out   (q_s43),
		.sat_out (sat_s43)
	);

	// ---------------- stage 44: special cases, output register ----------------
	logic signed [15:0] left_c, right_c, qs;
	awsp_pkg::status_t  stat_c;

	always_comb begin
		left_c = left_s[43];
		qs     = sat_s43 ? awsp_pkg::SPEED_MAX : 16'(q_s43);
		if (cs_s[43].at_robot) begin
			left_c  = '0;
			right_c = '0;
			stat_c  = awsp_pkg::ST_AT_ROBOT;
		end else if (cs_s[43].straight) begin
			right_c = left_s[43];
			stat_c  = awsp_pkg::ST_OK;
		end else if (cs_s[43].dzero) begin
			// pivot: full speed with the sign of left, zero if left is zero
			if (left_s[43] > 0)      right_c = awsp_pkg::SPEED_MAX;
			else if (left_s[43] < 0) right_c = -awsp_pkg::SPEED_MAX;
			else                     right_c = '0;
			stat_c = awsp_pkg::ST_PIVOT;
		end else begin
			right_c = cs_s[43].neg ? -qs : qs;
			stat_c  = sat_s43 ? awsp_pkg::ST_SAT : awsp_pkg::ST_OK;
		end
	end

	logic signed [15:0] left_s44, right_s44;
	awsp_pkg::status_t  stat_s44;

	always_ff @(posedge clk) begin
		if (en[44]) begin
			left_s44  <= left_c;
			right_s44 <= right_c;
			stat_s44  <= stat_c;
		end
	end

	assign m_tdata = {right_s44, left_s44};
	assign m_tuser = stat_s44;
endmodule
`default_nettype wire

// ===== rtl/core/awsp_hstep.sv =====
`default_nettype none
// One Horner step: t_out = 1 - ((x2 * t_in) >> 30) / K, three stages.
module awsp_hstep #(
	parameter int K = 2
) (
	input  wire logic        clk,
	input  wire logic [2:0]  en,
	input  wire logic [29:0] x2_in,
	input  wire logic [30:0] t_in,
	output logic      [29:0] x2_out,
	output logic      [30:0] t_out
);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
	localparam logic [6:0]  KD    = 7'(K);

	logic [29:0] x2_s1, x2_s2;
	logic [30:0] p_s1, p_s2, q0_s2;
	logic [60:0] prod_a;
	logic [62:0] prod_b;
	logic [37:0] qk;
	logic [30:0] rem, q;

	assign prod_a = 61'(x2_in) * 61'(t_in);
	assign prod_b = 63'(p_s1) * 63'(RECIP);
	assign qk     = 38'(q0_s2) * 38'(KD);
	// reciprocal estimate is exact or one short
	assign rem    = p_s2 - qk[30:0];
	assign q      = q0_s2 + 31'(rem >= 31'(KD));

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1  <= prod_a[60:30];
			x2_s1 <= x2_in;
		end
		if (en[1]) begin
			q0_s2 <= prod_b[62:32];
			p_s2  <= p_s1;
			x2_s2 <= x2_s1;
		end
		if (en[2]) begin
			t_out  <= awsp_pkg::ONE_Q30 - q;
			x2_out <= x2_s2;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/awsp_sincos.sv =====
`default_nettype none
// Sine and cosine in Q16 of a folded heading, 18 stages.
module awsp_sincos (
	input  wire logic                 clk,
	input  wire logic [17:0]          en,
	input  wire logic [12:0]          af_in,
	input  wire awsp_pkg::fold_t      fold_in,
	output logic signed [17:0]        sin_q16,
	output logic signed [17:0]        cos_q16
);
	logic [29:0] x_s0, x_s1, x2_s1;
	logic [29:0] x_d [2:13];
	awsp_pkg::fold_t fold_d [0:16];
	logic [30:0] s30_s14, s30_s15, s30_s16;
	logic [40:0] xm;
	logic [59:0] xsq;
	logic [60:0] sm;

	logic [29:0] cx2 [0:5];
	logic [30:0] ct  [0:5];
	logic [29:0] sx2 [0:4];
	logic [30:0] st  [0:4];

	assign xm  = 41'(af_in) * 41'(awsp_pkg::HALF_TURN_Q30_K) + 41'd512;
	assign xsq = 60'(x_s0) * 60'(x_s0);
	assign sm  = 61'(x_d[13]) * 61'(st[4]);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s0      <= xm[39:10];
			fold_d[0] <= fold_in;
		end
		if (en[1]) begin
			x2_s1 <= xsq[59:30];
			x_s1  <= x_s0;
		end
		if (en[2])
			x_d[2] <= x_s1;
		for (int i = 3; i <= 13; i++)
			if (en[i])
				x_d[i] <= x_d[i-1];
		for (int i = 1; i <= 16; i++)
			if (en[i])
				fold_d[i] <= fold_d[i-1];
		if (en[14]) s30_s14 <= sm[60:30];
		if (en[15]) s30_s15 <= s30_s14;
		if (en[16]) s30_s16 <= s30_s15;
	end

	assign cx2[0] = x2_s1;
	assign ct[0]  = awsp_pkg::ONE_Q30;
	assign sx2[0] = x2_s1;
	assign st[0]  = awsp_pkg::ONE_Q30;

	localparam int CK [0:4] = '{90, 56, 30, 12, 2};
	localparam int SK [0:3] = '{72, 42, 20, 6};

	for (genvar g = 0; g < 5; g++) begin : g_cos
		awsp_hstep #(.K(CK[g])) u_step (
			.clk    (clk),
			.en     (en[3*g+4:3*g+2]),
			.x2_in  (cx2[g]),
			.t_in   (ct[g]),
			.x2_out (cx2[g+1]),
			.t_out  (ct[g+1])
		);
	end

	for (genvar g = 0; g < 4; g++) begin : g_sin
		awsp_hstep #(.K(SK[g])) u_step (
			.clk    (clk),
			.en     (en[3*g+4:3*g+2]),
			.x2_in  (sx2[g]),
			.t_in   (st[g]),
			.x2_out (sx2[g+1]),
			.t_out  (st[g+1])
		);
	end

	// round Q30 to Q16, undo the fold
	logic [31:0] sr, cr;
	logic signed [17:0] s0, c0, sa, ca;

	always_comb begin
		sr = 32'(s30_s16) + 32'd8192;
		cr = 32'(ct[5]) + 32'd8192;
		if (fold_d[16].swap) begin
			s0 = 18'(cr[31:14]);
			c0 = 18'(sr[31:14]);
		end else begin
			s0 = 18'(sr[31:14]);
			c0 = 18'(cr[31:14]);
		end
		case (fold_d[16].quad)
			2'd0:    begin sa = s0;  ca = c0;  end
			2'd1:    begin sa = c0;  ca = -s0; end
			2'd2:    begin sa = -s0; ca = -c0; end
			default: begin sa = -c0; ca = s0;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[17]) begin
			sin_q16 <= sa;
			cos_q16 <= ca;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/awsp_div.sv =====
`default_nettype none
// Right speed magnitude: (n * base + d/2) / d, one quotient bit a stage, 18 stages.
module awsp_div #(
	parameter int W = 40
) (
	input  wire logic                           clk,
	input  wire logic [17:0]                    en,
	input  wire logic [W-1:0]                   n_in,
	input  wire logic [W-1:0]                   d_in,
	input  wire logic [14:0]                    base,
	output logic      [awsp_pkg::QBITS-1:0]     q_out,
	output logic                                sat_out
);
	localparam int NW = W + 16;
	localparam int QB = awsp_pkg::QBITS;

	logic [W+14:0] prod_s0;
	logic [W-1:0]  d_s [0:17];
	logic [NW-1:0] rem_s [1:17];
	logic [QB-1:0] q_s [2:17];
	logic          sat_s [2:17];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s0 <= (W+15)'(n_in) * (W+15)'(base);
			d_s[0]  <= d_in;
		end
		if (en[1]) begin
			rem_s[1] <= NW'(prod_s0) + NW'(d_s[0] >> 1);
			d_s[1]   <= d_s[0];
		end
		if (en[2]) begin
			sat_s[2] <= rem_s[1] >= (NW'(d_s[1]) << QB);
			rem_s[2] <= rem_s[1];
			q_s[2]   <= '0;
			d_s[2]   <= d_s[1];
		end
	end

	for (genvar g = 3; g <= 17; g++) begin : g_bit
		localparam int B = 17 - g;
		logic [NW-1:0] tr;
		logic          ge;
		assign tr = NW'(d_s[g-1]) << B;
		assign ge = rem_s[g-1] >= tr;
		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g] <= ge ? rem_s[g-1] - tr : rem_s[g-1];
				q_s[g]   <= q_s[g-1] | (ge ? QB'(1) << B : '0);
				sat_s[g] <= sat_s[g-1];
				d_s[g]   <= d_s[g-1];
			end
		end
	end

	assign q_out   = q_s[17];
	assign sat_out = sat_s[17];
endmodule
`default_nettype wire

// ===== rtl/core/awsp_checker.sv =====
`default_nettype none
module awsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_at_robot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == awsp_pkg::ST_AT_ROBOT |-> m_tdata == 32'd0)
		else $error("target at robot but speeds not zero");

	a_pivot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == awsp_pkg::ST_PIVOT |->
		m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8001 ||
		m_tdata[31:16] == 16'h0000)
		else $error("pivot right speed not at full scale");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == awsp_pkg::ST_SAT |->
		m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8001)
		else $error("saturated right speed not at limit");
endmodule

bind arc_wheel_speed_planner awsp_checker u_awsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/awsp_checker.sv =====
`timescale 1ns / 1ps
module awsp_scoreboard (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [87:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               results_seen
);
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		awsp_pkg::status_t  st;
	} speeds_t;

	speeds_t speeds_q[$];
	logic [7:0]  wheel_base;
	logic [14:0] base_speed;

	assign pending = speeds_q.size();

	// Q30 sine/cosine of a in [0, 4500] centidegrees, truncating Horner steps
	function automatic void taylor_q30(input longint unsigned a, output longint unsigned s,
			output longint unsigned c);
		longint unsigned one, x, x2, t;
		one = 64'd1 << 30;
		x = (a * 64'd191900981 + 64'd512) >> 10;
		x2 = (x * x) >> 30;
		t = one - x2 / 72;
		t = one - ((x2 * t) >> 30) / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		t = one - x2 / 90;
		t = one - ((x2 * t) >> 30) / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		t = one - ((x2 * t) >> 30) / 2;
		c = t;
	endfunction

	function automatic longint to_cm(longint v);
		longint w;
		w = v + 32768;
		if (w >= 0) return w >>> 16;
		return -((-w) >>> 16);
	endfunction

	function automatic speeds_t plan_arc(logic [87:0] d);
		longint rx, ry, hd, tx, ty, dx, dy, r, s0, c0, s, c, xx, yy, lft, rgt;
		longint unsigned s30, c30, a, q, bit_i;
		logic [127:0] sq, p, sum, dif, n, dn, num;
		logic b_neg, n_neg, d_neg, neg;
		speeds_t o;
		rx = longint'($signed(d[15:0]));
		ry = longint'($signed(d[31:16]));
		hd = longint'($signed(d[48:32]));
		tx = longint'($signed(d[64:49]));
		ty = longint'($signed(d[80:65]));
		dx = tx - rx;
		dy = ty - ry;
		r = hd % 36000;
		if (r < 0) r += 36000;
		q = r / 9000;
		a = r % 9000;
		if (a <= 4500) taylor_q30(a, s30, c30);
		else taylor_q30(9000 - a, c30, s30);
		s0 = longint'((s30 + 8192) >> 14);
		c0 = longint'((c30 + 8192) >> 14);
		case (q)
			0: begin s = s0; c = c0; end
			1: begin s = c0; c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
		xx = to_cm(dx * c + dy * s);
		yy = to_cm(dy * c - dx * s);
		lft = xx >= 0 ? longint'(base_speed) : -longint'(base_speed);
		o.st = awsp_pkg::ST_OK;
		if (xx == 0 && yy == 0) begin
			lft = 0; rgt = 0; o.st = awsp_pkg::ST_AT_ROBOT;
		end else if (yy == 0) begin
			rgt = lft;
		end else begin
			sq = 128'(xx * xx) + 128'(yy * yy);
			p = 128'(yy < 0 ? -yy : yy) * 128'(wheel_base);
			sum = sq + p;
			b_neg = sq < p;
			dif = b_neg ? p - sq : sq - p;
			if (yy > 0) begin n = sum; n_neg = 0; dn = dif; d_neg = b_neg; end
			else begin n = dif; n_neg = b_neg; dn = sum; d_neg = 0; end
			if (dn == 0) begin
				rgt = lft > 0 ? 32767 : (lft < 0 ? -32767 : 0);
				o.st = awsp_pkg::ST_PIVOT;
			end else begin
				num = n * 128'(base_speed) + (dn >> 1);
				neg = (lft < 0) != (n_neg != d_neg);
				if (num >= (dn << 15)) begin
					bit_i = 32767; o.st = awsp_pkg::ST_SAT;
				end else bit_i = longint'(num / dn);
				rgt = neg ? -longint'(bit_i) : longint'(bit_i);
			end
		end
		o.left = 16'(lft);
		o.right = 16'(rgt);
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		speeds_t e;
		int errs;
		if (!arst_n) begin
			wheel_base <= awsp_pkg::WHEEL_BASE_RST;
			base_speed <= awsp_pkg::BASE_SPEED_RST;
			fail_count <= 0;
			results_seen <= 0;
			speeds_q.delete();
		end else begin
			errs = 0;
			if (s_tvalid && s_tready) speeds_q.push_back(plan_arc(s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (speeds_q.size() == 0) begin
					$error("unexpected result %h/%h", m_tdata, m_tuser);
					errs++;
				end else begin
					e = speeds_q.pop_front();
					if (m_tdata[15:0] !== e.left) begin
						$error("left_speed exp %0d got %0d", e.left, $signed(m_tdata[15:0]));
						errs++;
					end
					if (m_tdata[31:16] !== e.right) begin
						$error("right_speed exp %0d got %0d", e.right,
							$signed(m_tdata[31:16]));
						errs++;
					end
					if (m_tuser !== e.st) begin
						$error("status exp %0d got %0d", e.st, m_tuser);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == awsp_pkg::REG_WHEEL_BASE) wheel_base <= cfg_data[7:0];
				else if (cfg_index == awsp_pkg::REG_BASE_SPEED) base_speed <= cfg_data;
			end
		end
	end
endmodule

// ===== verif/tb_arc_wheel_speed_planner.sv =====
`timescale 1ns / 1ps
module tb_arc_wheel_speed_planner;
	// index with no register behind it
	localparam logic [1:0] REG_UNKNOWN = 2'd3;

	typedef struct { logic [14:0] wb; logic [14:0] sp; } setting_t;
	setting_t cfg_index_list[5] = '{
		'{15'd1, 15'd32767}, '{15'd255, 15'd0}, '{15'd0, 15'd1000},
		'{15'd200, 15'd20000}, '{15'd50, 15'd1500}};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;   // robot_x, robot_y, heading(17), target_x, target_y, pad
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // left_speed, right_speed
	logic [1:0]  m_tuser;   // status
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	int          fail_count, pending, results_seen;
	logic        long_stall;  // asks the receiver for one long hold-off

	arc_wheel_speed_planner dut (.*);

	awsp_scoreboard chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Receiver: own stall pattern, plus one long hold-off to fill the pipe
	initial begin
		int held;
		held = 0;
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (long_stall && held < 200) begin
				held++;
				m_tready <= 0;
			end else case ((results_seen / 150) % 3)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	task automatic put_item(input logic signed [15:0] rx, ry, tx, ty,
			input logic signed [16:0] hd);
		s_tvalid <= 1;
		s_tdata <= {7'd0, ty, tx, hd, ry, rx};
		do @(posedge clk); while (!s_tready);
	endtask

	// bursty sender; leaves valid high across a burst
	task automatic send_random(input int count);
		int burst;
		int r;
		logic signed [15:0] rx, ry;
		while (count > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && count > 0) begin
				r = $urandom_range(0, 9);
				rx = 16'($urandom);
				ry = 16'($urandom);
				if (r < 5)  // near targets: small offsets, arcs and pivots
					put_item(rx, ry, rx + 16'($signed($urandom_range(0, 120)) - 60),
						ry + 16'($signed($urandom_range(0, 120)) - 60),
						17'($signed($urandom_range(0, 72000)) - 36000));
				else if (r < 6)  // on axis: straight, behind or to the side
					put_item(rx, ry, rx + 16'($signed($urandom_range(0, 2000)) - 1000),
						ry, 17'($signed($urandom_range(0, 8)) * 9000 - 36000));
				else
					put_item(rx, ry, 16'($urandom), 16'($urandom),
						17'($signed($urandom_range(0, 72000)) - 36000));
				burst--; count--;
			end
			s_tvalid <= 0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
		s_tvalid <= 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (pending != 0 && n < 100000) begin @(posedge clk); n++; end
		repeat (60) @(posedge clk);
	endtask

	initial begin
		arst_n = 0; s_tvalid = 0; s_tdata = '0; long_stall = 0;
		cfg_valid = 0; cfg_index = awsp_pkg::REG_WHEEL_BASE; cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: at robot, straight, behind, extremes, pivot, saturation
		put_item(0, 0, 0, 0, 0);
		put_item(100, 100, 100, 100, 12345);
		put_item(0, 0, 500, 0, 0);
		put_item(0, 0, -500, 0, 0);
		put_item(0, 0, 0, 500, 9000);
		put_item(-32768, -32768, 32767, 32767, 36000);
		put_item(32767, 32767, -32768, -32768, -36000);
		put_item(0, 0, 0, 50, 0);        // pivot with b=50: S = b*yy
		put_item(0, 0, 1, 49, 0);        // near pivot: saturation
		put_item(0, 0, 0, -25, 0);
		put_item(0, 0, 30, 40, 4500);
		put_item(0, 0, 30, -40, -4500);
		put_item(0, 0, 10, 10, 27000);
		put_item(0, 0, 10, 10, 18000);
		put_item(0, 0, 10, 10, -1);
		put_item(-1, 0, 32767, -32768, 35999);
		s_tvalid <= 0;
		drain();

		// hold-off: sender keeps offering while output is blocked
		long_stall = 1;
		send_random(150);
		drain();

		foreach (cfg_index_list[k]) begin
			write_reg(awsp_pkg::REG_WHEEL_BASE, cfg_index_list[k].wb);
			write_reg(awsp_pkg::REG_BASE_SPEED, cfg_index_list[k].sp);
			if (cfg_index_list[k].wb == 1) write_reg(REG_UNKNOWN, 15'h7fff);
			send_random(130);
			drain();
		end

		$display("covered %0d results over 5 register settings incl. width extremes",
			results_seen);
		$display("directed pose/target corners, near-pivot arcs and back-pressure hold-off");
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#30ms;
		$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/awsp_pkg.sv
rtl/core/awsp_hstep.sv
rtl/core/awsp_sincos.sv
rtl/core/awsp_div.sv
rtl/core/arc_wheel_speed_planner.sv
rtl/core/awsp_checker.sv
verif/awsp_checker.sv
verif/tb_arc_wheel_speed_planner.sv
